/* rtl/bpme_pkg.sv */
// bpme_pkg: shared constants, types and helpers for the byte pattern match engine.
// No dependencies; imported by byte_pattern_match_engine_unit.
`default_nettype none

package bpme_pkg;

  localparam int PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF   = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PLEN_W     = 5;
  localparam int MATCH_W    = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_TEXT_MODE      = 3'd3,
    CFG_CASE_SENSITIVE = 3'd4,
    CFG_WIDE_CHARS     = 3'd5,
    CFG_REVERSE_ORDER  = 3'd6
  } cfg_reg_t;

  localparam logic [7:0] UPPER_A    = 8'd65;
  localparam logic [7:0] UPPER_Z    = 8'd90;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  // One result item
  typedef struct packed {
    logic [MATCH_W-1:0] offset;
    logic               wide;
    logic               last;
  } result_t;

  // Fold A-Z to a-z unless the compare is exact
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic exact);
    if (!exact && b >= UPPER_A && b <= UPPER_Z) begin
      return b + CASE_DELTA;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/byte_pattern_match_engine_unit.sv */
// byte_pattern_match_engine_unit: top level of the byte pattern match engine.
// Depends on bpme_pkg (constants, result_t, fold_byte).
`default_nettype none

// Scans a byte stream for a pattern of 1..PATTERN_BYTES bytes and reports the start
// offset of each match when the last byte of the match arrives. Binary mode compares
// raw bytes (pattern optionally reversed) and reports greedy non-overlapping matches;
// text mode reports overlapping matches, folds A-Z unless case sensitive, and with
// wide_chars also finds the pattern with a zero byte between characters (a start that
// already matched plainly is not repeated). Up to two result items per input item,
// wide hit first. All compares run in parallel in the accept cycle against a shift
// line of the last 2*PATTERN_BYTES-1 bytes; results enter a 4-entry result queue and
// are offered on out_tvalid from the cycle after their input item is accepted.
// Rate: one input item per cycle while each item gives at most one result; the output
// side moves one result per cycle, so items with two hits are limited by it. in_tready
// drops while more than two results wait in the queue. in_tlast ends the buffer and
// clears all run state (offset count, history, overlap guard); registers persist.
module byte_pattern_match_engine_unit
  import bpme_pkg::*;
#(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // final_byte
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [MATCH_W-1:0]    out_tdata,  // [31:0] match_offset
  output logic [0:0]            out_tuser,  // [0] wide_hit
  output logic                  out_tlast   // run_end
);

  localparam int WIN_BYTES = 2 * PATTERN_BYTES - 1;
  localparam int LEN_W     = $clog2(PATTERN_BYTES + 1);
  localparam int FILL_W    = $clog2(2 * PATTERN_BYTES);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  // ---------------- configuration registers ----------------
  logic [63:0]       pat_low_r, pat_high_r;
  logic [PLEN_W-1:0] plen_r;
  logic              text_r, exact_r, wide_en_r, rev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      plen_r     <= PLEN_W'(1);
      text_r     <= 1'b0;
      exact_r    <= 1'b0;
      wide_en_r  <= 1'b1;
      rev_r      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_LOW:    pat_low_r  <= cfg_wdata;
        CFG_PATTERN_HIGH:   pat_high_r <= cfg_wdata;
        CFG_PATTERN_LENGTH: plen_r     <= cfg_wdata[PLEN_W-1:0];
        CFG_TEXT_MODE:      text_r     <= cfg_wdata[0];
        CFG_CASE_SENSITIVE: exact_r    <= cfg_wdata[0];
        CFG_WIDE_CHARS:     wide_en_r  <= cfg_wdata[0];
        CFG_REVERSE_ORDER:  rev_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- run state ----------------
  logic [7:0]             win_r [WIN_BYTES];   // [0] is the newest byte
  logic [FILL_W-1:0]      fill_r;
  logic [PATTERN_BYTES-1:0] hist_r;            // plain hit ended at byte k back
  logic [OFFSET_BITS-1:0] cnt_r;
  logic [OFFSET_BITS-1:0] nas_r;               // next allowed binary start
  logic                   armed_r;

  // ---------------- result queue ----------------
  result_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   q_cnt_r;

  logic in_fire, out_fire;
  assign in_tready  = (q_cnt_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (q_cnt_r != '0);
  assign out_fire   = out_tvalid && out_tready;
  assign out_tdata  = q_r[rd_ptr_r].offset;
  assign out_tuser  = q_r[rd_ptr_r].wide;
  assign out_tlast  = q_r[rd_ptr_r].last;

  // ---------------- effective length and pattern ----------------
  logic [LEN_W-1:0] len;
  always_comb begin
    if (plen_r == '0) begin
      len = LEN_W'(1);
    end else if (int'(plen_r) > PATTERN_BYTES) begin
      len = LEN_W'(PATTERN_BYTES);
    end else begin
      len = LEN_W'(plen_r);
    end
  end

  logic [7:0] pat_b [PATTERN_BYTES];
  for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_pat
    if (k < 8) begin : g_lo
      assign pat_b[k] = pat_low_r[8*k +: 8];
    end else if (k < 16) begin : g_hi
      assign pat_b[k] = pat_high_r[8*(k-8) +: 8];
    end else begin : g_zero
      assign pat_b[k] = 8'd0;
    end
  end

  // Expected byte at window position j (j bytes back from the match end).
  // Wide compares use the same byte at position 2j.
  logic [7:0] exp_b [PATTERN_BYTES];
  always_comb begin
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      exp_b[j] = 8'd0;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
        if ((!text_r && rev_r) ? (k == j) : (k == int'(len) - 1 - j)) begin
          exp_b[j] = pat_b[k];
        end
      end
      if (text_r) begin
        exp_b[j] = fold_byte(exp_b[j], exact_r);
      end
    end
  end

  // ---------------- window shift and compares ----------------
  logic [7:0]        win_new [WIN_BYTES];
  logic [FILL_W-1:0] fill_inc;

  always_comb begin
    win_new[0] = in_tdata;
    for (int i = 1; i < WIN_BYTES; i++) begin
      win_new[i] = win_r[i-1];
    end
  end

  assign fill_inc = (int'(fill_r) == WIN_BYTES) ? fill_r : fill_r + FILL_W'(1);

  logic narrow, wide_raw, dup, wide;
  always_comb begin
    narrow = (int'(fill_inc) >= int'(len));
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      if (j < int'(len)) begin
        if ((text_r ? fold_byte(win_new[j], exact_r) : win_new[j]) != exp_b[j]) begin
          narrow = 1'b0;
        end
      end
    end
  end

  always_comb begin
    wide_raw = text_r && wide_en_r && (int'(len) >= 2) &&
               (int'(fill_inc) >= 2 * int'(len) - 1);
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      if (j < int'(len) && fold_byte(win_new[2*j], exact_r) != exp_b[j]) begin
        wide_raw = 1'b0;
      end
    end
    // zero bytes between characters
    for (int j = 0; j < PATTERN_BYTES - 1; j++) begin
      if (j < int'(len) - 1 && win_new[2*j+1] != 8'd0) begin
        wide_raw = 1'b0;
      end
    end
  end

  // same start already gave a plain hit len-1 bytes ago
  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      if (k + 2 == int'(len)) begin
        dup = hist_r[k];
      end
    end
  end
  assign wide = wide_raw && !dup;

  // ---------------- start offsets and binary overlap guard ----------------
  logic [OFFSET_BITS-1:0]         len_ext, s_narrow, s_wide, start_gap;
  logic [OFFSET_BITS+MATCH_W-1:0] sn_ext, sw_ext;
  logic                           suppress, bin_emit;

  assign len_ext   = OFFSET_BITS'(len);
  assign s_narrow  = cnt_r - len_ext + OFFSET_BITS'(1);
  assign s_wide    = cnt_r - (len_ext << 1) + OFFSET_BITS'(2);
  assign start_gap = nas_r - s_narrow;
  assign suppress  = armed_r && (start_gap != '0) && (start_gap < len_ext);
  assign bin_emit  = !text_r && narrow && !suppress;
  assign sn_ext    = {{MATCH_W{1'b0}}, s_narrow};
  assign sw_ext    = {{MATCH_W{1'b0}}, s_wide};

  // ---------------- result assembly ----------------
  result_t    res0, res1;
  logic [1:0] n_res;
  always_comb begin
    res0  = '{offset: sn_ext[MATCH_W-1:0], wide: 1'b0, last: 1'b1};
    res1  = '{offset: sn_ext[MATCH_W-1:0], wide: 1'b0, last: 1'b1};
    n_res = 2'd0;
    if (text_r) begin
      if (wide) begin
        res0  = '{offset: sw_ext[MATCH_W-1:0], wide: 1'b1, last: !narrow};
        n_res = narrow ? 2'd2 : 2'd1;
      end else if (narrow) begin
        n_res = 2'd1;
      end
    end else if (bin_emit) begin
      n_res = 2'd1;
    end
  end

  // ---------------- state updates ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r <= win_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      hist_r  <= '0;
      cnt_r   <= '0;
      nas_r   <= '0;
      armed_r <= 1'b0;
    end else if (in_fire) begin
      if (in_tlast) begin
        fill_r  <= '0;
        hist_r  <= '0;
        cnt_r   <= '0;
        nas_r   <= '0;
        armed_r <= 1'b0;
      end else begin
        fill_r <= fill_inc;
        hist_r <= PATTERN_BYTES'({hist_r, narrow});
        cnt_r  <= cnt_r + OFFSET_BITS'(1);
        if (bin_emit) begin
          nas_r   <= s_narrow + len_ext;
          armed_r <= 1'b1;
        end
      end
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (in_fire && n_res == 2'd2) begin
      q_r[Q_PTR_W'(wr_ptr_r + Q_PTR_W'(1))] <= res1;
    end
  end

  // queue control
  logic [Q_CNT_W-1:0] push_n;
  assign push_n = in_fire ? Q_CNT_W'(n_res) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_PTR_W'(push_n);
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + push_n - Q_CNT_W'(out_fire);
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
// tb: self-checking testbench for byte_pattern_match_engine_unit.
// Drives bytes and config writes, predicts match offsets, checks every result item.
// Depends on bpme_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;
  import bpme_pkg::*;

  // one input item: a buffer byte and its end-of-buffer flag
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_item_t;

  localparam int WIN_BYTES   = 2 * PATTERN_BYTES_DEF - 1;
  localparam int PHASE_ITEMS = 155;
  localparam int STALL_LEN   = 400;
  localparam int DRAIN_WAIT  = 16;
  localparam int QUIET_LIMIT = 3000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;    // [7:0] data_byte
  logic                  in_tlast = 1'b0;  // final_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [MATCH_W-1:0]    out_tdata;        // [31:0] match_offset
  logic [0:0]            out_tuser;        // [0] wide_hit
  logic                  out_tlast;        // run_end

  byte_pattern_match_engine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Register shadow and match predictor
  // ---------------------------------------------------------------------------
  logic [63:0] pat_lo, pat_hi;
  logic [4:0]  pat_len;
  bit          txt_mode, exact_case, wide_en, rev_order;

  logic [7:0]  win [WIN_BYTES];   // win[0] is the newest byte
  logic [15:0] plain_hist;        // bit n: plain match ended n bytes back
  logic [31:0] run_offset;
  logic [31:0] next_start;
  int          win_fill;
  bit          bin_armed;

  result_t     hits_due[$];       // match results still to come out
  byte_item_t  bytes_to_send[$];  // items waiting for the driver
  int          errors = 0;

  function automatic int eff_len();
    if (pat_len < 1) return 1;
    if (pat_len > PATTERN_BYTES_DEF) return PATTERN_BYTES_DEF;
    return int'(pat_len);
  endfunction

  function automatic logic [7:0] pat_at(int k);
    if (k < 8) return pat_lo[8*k +: 8];
    if (k < 16) return pat_hi[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] b);
    if (!exact_case && b >= UPPER_A && b <= UPPER_Z) return b + CASE_DELTA;
    return b;
  endfunction

  // run state clears after reset and after every final byte
  function automatic void clear_run();
    foreach (win[i]) win[i] = 8'h00;
    plain_hist = '0;
    run_offset = '0;
    next_start = '0;
    win_fill   = 0;
    bin_armed  = 1'b0;
  endfunction

  // one accepted byte: update the window and queue the matches it completes
  task automatic scan_byte(input logic [7:0] data, input logic fin);
    logic [31:0] t, s, start_gap;
    logic [7:0]  d, p;
    result_t     found[$];
    result_t     r;
    int          len, top, i;
    bit          narrow, wide;
    t   = run_offset;
    len = eff_len();
    for (i = WIN_BYTES - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = data;
    if (win_fill < WIN_BYTES) win_fill++;

    // plain compare, start len-1 bytes back
    narrow = 1'b0;
    if (win_fill >= len) begin
      narrow = 1'b1;
      for (i = 0; i < len; i++) begin
        d = win[len-1-i];
        if (txt_mode) begin
          d = to_lower(d);
          p = to_lower(pat_at(i));
        end else begin
          p = rev_order ? pat_at(len-1-i) : pat_at(i);
        end
        if (d != p) narrow = 1'b0;
      end
    end
    plain_hist = {plain_hist[14:0], narrow};

    // zero-interleaved compare, start 2*len-2 bytes back
    wide = 1'b0;
    if (txt_mode && wide_en && len >= 2 && win_fill >= 2 * len - 1) begin
      top  = 2 * len - 2;
      wide = to_lower(win[top]) == to_lower(pat_at(0));
      for (i = 1; i < len; i++) begin
        if (win[top-(2*i-1)] != 8'h00 || to_lower(win[top-2*i]) != to_lower(pat_at(i)))
          wide = 1'b0;
      end
      // same start already reported as a plain match
      if (wide && plain_hist[len-1]) wide = 1'b0;
    end

    if (txt_mode) begin
      if (wide) begin
        r.offset = t - 32'(2 * len - 2);
        r.wide = 1'b1;
        r.last = 1'b0;
        found.push_back(r);
      end
      if (narrow) begin
        r.offset = t - 32'(len - 1);
        r.wide = 1'b0;
        r.last = 1'b0;
        found.push_back(r);
      end
    end else if (narrow) begin
      // greedy non-overlap: skip starts inside the last reported match
      s         = t - 32'(len - 1);
      start_gap = next_start - s;
      if (!(bin_armed && start_gap >= 1 && start_gap < len)) begin
        r.offset = s;
        r.wide = 1'b0;
        r.last = 1'b0;
        found.push_back(r);
        next_start = s + 32'(len);
        bin_armed  = 1'b1;
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) hits_due.push_back(found[i]);

    run_offset = t + 32'd1;
    if (fin) clear_run();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, random gap drawn per item
  // ---------------------------------------------------------------------------
  byte_item_t tx_cur = '0;
  bit         tx_busy = 1'b0;
  bit         tx_quiet = 1'b0;
  int         tx_gap = 0;

  // random wait between items, often none, none at all during a quiet stretch
  function automatic int draw_wait(bit quiet);
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tx_busy = 1'b0;
      tx_gap  = 0;
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) tx_busy = 1'b0;
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (bytes_to_send.size() > 0) begin
          tx_cur  = bytes_to_send.pop_front();
          tx_busy = 1'b1;
          if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
          tx_gap = draw_wait(tx_quiet);
        end
      end
      in_tvalid <= tx_busy;
      in_tdata  <= tx_cur.data;
      in_tlast  <= tx_cur.fin;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input accept, checks result items, paces out_tready
  // ---------------------------------------------------------------------------
  int  stall_req = 0;     // long hold-offs asked by the sequence
  int  stall_taken = 0;
  int  rx_hold = 0;
  int  rx_gap = 0;
  bit  rx_quiet = 1'b0;

  task automatic log_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch %0d: %s", errors, msg);
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    bit      rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      // predict first so a same-edge result still finds its expectation
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (hits_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result offset %h wide %0d end %0d",
                                 out_tdata, out_tuser[0], out_tlast));
        end else begin
          want = hits_due.pop_front();
          if (out_tdata !== want.offset || out_tuser[0] !== want.wide ||
              out_tlast !== want.last)
            log_mismatch($sformatf("offset exp %h got %h, wide exp %0d got %0d, end exp %0d got %0d",
                                   want.offset, out_tdata, want.wide, out_tuser[0],
                                   want.last, out_tlast));
        end
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        rx_gap = draw_wait(rx_quiet);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rdy = 1'b0;
      end else if (stall_taken < stall_req) begin
        // long hold-off: the result queue fills and the input side backs up
        stall_taken++;
        rx_hold = STALL_LEN - 1;
        rdy = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any handshake or register write
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  task automatic send(input logic [7:0] data, input logic fin);
    byte_item_t it;
    it.data = data;
    it.fin  = fin;
    bytes_to_send.push_back(it);
  endtask

  // register write; narrow registers get random upper bits that must be ignored
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v, input int width);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (width < 64) ? ((noise << width) | v) : v;
    case (idx)
      CFG_PATTERN_LOW:    pat_lo     = v;
      CFG_PATTERN_HIGH:   pat_hi     = v;
      CFG_PATTERN_LENGTH: pat_len    = v[4:0];
      CFG_TEXT_MODE:      txt_mode   = v[0];
      CFG_CASE_SENSITIVE: exact_case = v[0];
      CFG_WIDE_CHARS:     wide_en    = v[0];
      CFG_REVERSE_ORDER:  rev_order  = v[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input bit txt, input bit ex,
                             input bit wd, input bit rv);
    write_reg(CFG_PATTERN_LOW, lo, 64);
    write_reg(CFG_PATTERN_HIGH, hi, 64);
    write_reg(CFG_PATTERN_LENGTH, 64'(len), PLEN_W);
    write_reg(CFG_TEXT_MODE, 64'(txt), 1);
    write_reg(CFG_CASE_SENSITIVE, 64'(ex), 1);
    write_reg(CFG_WIDE_CHARS, 64'(wd), 1);
    write_reg(CFG_REVERSE_ORDER, 64'(rv), 1);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the driver and the result side to drain, then the pipeline latency
  task automatic settle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || tx_busy || hits_due.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // pattern bytes: letters of both cases, zeros, all-ones and noise
  function automatic logic [7:0] rand_pat_byte();
    case ($urandom_range(0, 5))
      0, 1:    return 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One buffer of target bytes: pattern occurrences (plain, case flipped, zero
  // interleaved, sometimes corrupted) mixed with filler. Cut at target, so a
  // trailing occurrence may run past the buffer end.
  task automatic add_buffer(input int target, input bit close);
    logic [7:0] chunk_q[$];
    logic [7:0] seq[$];
    logic [7:0] b;
    int         len, i, n;
    bit         as_wide;
    len = eff_len();
    while (chunk_q.size() < target) begin
      if ($urandom_range(0, 9) < 4) begin
        seq.delete();
        for (i = 0; i < len; i++) begin
          b = (!txt_mode && rev_order) ? pat_at(len-1-i) : pat_at(i);
          if (txt_mode && !exact_case && $urandom_range(0, 1) &&
              ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)))
            b ^= 8'h20;
          seq.push_back(b);
        end
        if ($urandom_range(0, 4) == 0) seq[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
        as_wide = txt_mode && wide_en && $urandom_range(0, 1);
        for (i = 0; i < len; i++) begin
          if (as_wide && i > 0) chunk_q.push_back(8'h00);
          chunk_q.push_back(seq[i]);
        end
      end else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0:       b = 8'($urandom_range(0, 255));
            1:       b = pat_at($urandom_range(0, len - 1));
            2:       b = 8'h00;
            default: b = rand_pat_byte();
          endcase
          chunk_q.push_back(b);
        end
      end
    end
    while (chunk_q.size() > target) void'(chunk_q.pop_back());
    for (i = 0; i < chunk_q.size(); i++) send(chunk_q[i], close && (i == chunk_q.size() - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] lo, hi;
    logic [4:0]  len;
    bit          txt, ex, wd, rv;
    int          ph, k, left, n;

    // register reset values
    pat_lo = '0;  pat_hi = '0;  pat_len = 5'd1;
    txt_mode = 1'b0;  exact_case = 1'b0;  wide_en = 1'b1;  rev_order = 1'b1;
    clear_run();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset config: binary, one zero byte; every zero matches. No final byte,
    // so the run carries over into the next setting.
    send(8'h00, 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b0);
    settle();

    // text, "A\0": folding, zero-interleaved hit on an already plain start,
    // a match cut off by the final byte
    load_config(64'h0041, 64'h0, 5'd2, 1'b1, 1'b0, 1'b1, 1'b0);
    @(negedge clk);
    send("a", 1'b0);
    send(8'h00, 1'b0);
    send(8'h00, 1'b0);
    send("A", 1'b0);
    send(8'h00, 1'b0);
    send("b", 1'b0);
    send("x", 1'b0);
    send("A", 1'b1);
    settle();

    // length zero acts as one
    load_config(64'hFF, 64'h0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    @(negedge clk);
    send(8'hFF, 1'b0);
    send(8'hFF, 1'b1);
    settle();

    // binary overlap: "aaa" in six a's gives two matches
    load_config(64'h616161, 64'h0, 5'd3, 1'b0, 1'b0, 1'b0, 1'b1);
    @(negedge clk);
    for (k = 0; k < 6; k++) send("a", k == 5);
    settle();

    // single byte in text mode, exact case
    load_config(64'h5A, 64'h0, 5'd1, 1'b1, 1'b1, 1'b1, 1'b0);
    @(negedge clk);
    send("Z", 1'b0);
    send("z", 1'b0);
    send(8'h00, 1'b0);
    send("Z", 1'b1);
    settle();

    // random phases, each with its own setting and extremes forced in some
    for (ph = 0; ph < 11; ph++) begin
      for (k = 0; k < 8; k++) begin
        lo[8*k +: 8] = rand_pat_byte();
        hi[8*k +: 8] = rand_pat_byte();
      end
      len = 5'($urandom_range(1, 16));
      txt = 1'($urandom_range(0, 1));
      ex  = 1'($urandom_range(0, 1));
      wd  = 1'($urandom_range(0, 1));
      rv  = 1'($urandom_range(0, 1));
      case (ph)
        0:  begin txt = 1; len = 5'd1; lo[7:0] = "a"; ex = 0; end
        1:  begin txt = 0; len = 5'd16; rv = 0; end
        2:  begin txt = 0; len = 5'd16; rv = 1; lo = '1; hi = '1; end
        3:  begin txt = 1; len = 5'd16; ex = 0; wd = 1; end
        4:  begin txt = 1; len = 5'd5; ex = 1; wd = 1; end
        5:  begin txt = 0; len = 5'd0; lo = '0; hi = '0; end
        6:  begin txt = 1; len = 5'd31; ex = 0; wd = 0; end
        7:  begin txt = 0; len = 5'd3; rv = 1; lo[23:0] = 24'h616261; end
        8:  begin txt = 1; len = 5'd2; ex = 0; wd = 1; lo[15:0] = 16'h0041; end
        9:  begin txt = 0; len = 5'd17; rv = 0; lo = '0; hi = '0; end
        default: ;
      endcase
      load_config(lo, hi, len, txt, ex, wd, rv);
      @(negedge clk);
      // hit-dense first phase: receiver holds off while bytes keep coming
      if (ph == 0) stall_req = 1;
      left = PHASE_ITEMS;
      while (left > 0) begin
        n = $urandom_range(1, 80);
        if (n > left) n = left;
        add_buffer(n, (n < left) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 3) != 0));
        left -= n;
      end
      // sender pauses here until every result is out
      settle();
    end

    if (errors == 0 && hits_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
